@@ hdl/ilu_pkg.sv @@
// ----------------------------------------------------------------------------
// ilu_pkg: shared types, constants and fixed-point helpers
// Saturating Q4.28 / Q8.24 arithmetic, register indexes and the per-point
// context that travels with every point through the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ilu_pkg;

	// number of refinement passes, each a pipeline section of its own
	localparam int ITERATIONS = 20;
	// quotient bits produced by the divider, one per stage
	localparam int DIV_STEPS  = 32;

	// register indexes on the configuration port
	localparam logic [2:0] REG_K1 = 3'd0;
	localparam logic [2:0] REG_K2 = 3'd1;
	localparam logic [2:0] REG_K3 = 3'd2;
	localparam logic [2:0] REG_P1 = 3'd3;
	localparam logic [2:0] REG_P2 = 3'd4;

	localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
	localparam logic signed [65:0] ONE_Q24 = 66'sd16777216;
	localparam logic signed [31:0] MAX32   = 32'sh7fffffff;
	localparam logic signed [31:0] MIN32   = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] k1;
		logic signed [31:0] k2;
		logic signed [31:0] k3;
		logic signed [31:0] p1;
		logic signed [31:0] p2;
	} coef_t;

	typedef struct packed {
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic               bad;
	} ctx_t;

	// clamp to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > SAT_MAX) begin
			return MAX32;
		end else if (v < SAT_MIN) begin
			return MIN32;
		end
		return v[31:0];
	endfunction

	// exact product, floor shift, clamp
	function automatic logic signed [31:0] mul_sh(input logic signed [31:0] a,
			input logic signed [31:0] b, input int s);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat32(66'(p >>> s));
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(66'(a) + 66'(b));
	endfunction

endpackage

`default_nettype wire

@@ hdl/ilu_front.sv @@
// ----------------------------------------------------------------------------
// ilu_front: polynomial and offset section of one pass
// Five stages: squares, r2 and first Horner step, tangential products,
// numerators, radial factor.
// ----------------------------------------------------------------------------
`default_nettype none

module ilu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  ilu_pkg::ctx_t      ctx,
	input  ilu_pkg::coef_t     coef,
	output logic               vout,
	output ilu_pkg::ctx_t      ctx_out,
	output logic signed [31:0] nx,
	output logic signed [31:0] ny,
	output logic signed [31:0] k
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	ilu_pkg::ctx_t      ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5;
	logic signed [31:0] xx_s1, yy_s1, xy_s1;
	logic signed [31:0] r2_s2, h_s2, a_s2, b_s2, xy_s2;
	logic signed [31:0] r2_s3, h_s3, tx1_s3, tx2_s3, ty1_s3, ty2_s3;
	logic signed [31:0] h_s4, nx_s4, ny_s4;
	logic signed [31:0] k_s5, nx_s5, ny_s5;
	logic signed [31:0] r2, tx, ty;

	assign r2 = ilu_pkg::add_sat(xx_s1, yy_s1);
	assign tx = ilu_pkg::add_sat(ilu_pkg::sat32(66'(tx1_s3) <<< 1), tx2_s3);
	assign ty = ilu_pkg::add_sat(ilu_pkg::sat32(66'(ty1_s3) <<< 1), ty2_s3);

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			// squares and cross product
			ctx_s1 <= ctx;
			xx_s1  <= ilu_pkg::mul_sh(x, x, 28);
			yy_s1  <= ilu_pkg::mul_sh(y, y, 28);
			xy_s1  <= ilu_pkg::mul_sh(x, y, 28);
			// r2, first Horner product, tangential terms
			ctx_s2 <= ctx_s1;
			r2_s2  <= r2;
			h_s2   <= ilu_pkg::mul_sh(coef.k3, r2, 28);
			a_s2   <= ilu_pkg::sat32(66'(r2) + (66'(xx_s1) <<< 1));
			b_s2   <= ilu_pkg::sat32(66'(r2) + (66'(yy_s1) <<< 1));
			xy_s2  <= xy_s1;
			// second Horner step, tangential products
			ctx_s3 <= ctx_s2;
			r2_s3  <= r2_s2;
			h_s3   <= ilu_pkg::mul_sh(ilu_pkg::add_sat(h_s2, coef.k2), r2_s2, 28);
			tx1_s3 <= ilu_pkg::mul_sh(coef.p1, xy_s2, 24);
			tx2_s3 <= ilu_pkg::mul_sh(coef.p2, a_s2, 24);
			ty1_s3 <= ilu_pkg::mul_sh(coef.p2, xy_s2, 24);
			ty2_s3 <= ilu_pkg::mul_sh(coef.p1, b_s2, 24);
			// third Horner step, numerators
			ctx_s4 <= ctx_s3;
			h_s4   <= ilu_pkg::mul_sh(ilu_pkg::add_sat(h_s3, coef.k1), r2_s3, 28);
			nx_s4  <= ilu_pkg::sat32(66'(ctx_s3.dx) - 66'(tx));
			ny_s4  <= ilu_pkg::sat32(66'(ctx_s3.dy) - 66'(ty));
			// radial factor
			ctx_s5 <= ctx_s4;
			k_s5   <= ilu_pkg::sat32(66'(h_s4) + ilu_pkg::ONE_Q24);
			nx_s5  <= nx_s4;
			ny_s5  <= ny_s4;
		end
	end

	assign vout    = v_s5;
	assign ctx_out = ctx_s5;
	assign nx      = nx_s5;
	assign ny      = ny_s5;
	assign k       = k_s5;

endmodule

`default_nettype wire

@@ hdl/ilu_div.sv @@
// ----------------------------------------------------------------------------
// ilu_div: pipelined divider for both coordinates of one pass
// Setup stage, one restoring step per stage for 32 quotient bits, then sign,
// saturation and the bad-divisor bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module ilu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  ilu_pkg::ctx_t      ctx,
	input  logic signed [31:0] nx,
	input  logic signed [31:0] ny,
	input  logic signed [31:0] k,
	output logic               vout,
	output ilu_pkg::ctx_t      ctx_out,
	output logic signed [31:0] x,
	output logic signed [31:0] y
);

	localparam int N = ilu_pkg::DIV_STEPS;

	logic               v_s   [0:N];
	ilu_pkg::ctx_t      ctx_s [0:N];
	logic [31:0]        k_s   [0:N];
	logic               kbad_s[0:N];
	logic signed [31:0] nx_s  [0:N];
	logic signed [31:0] ny_s  [0:N];
	logic               ngx_s [0:N];
	logic               ngy_s [0:N];
	logic               ovx_s [0:N];
	logic               ovy_s [0:N];
	logic [31:0]        rmx_s [0:N];
	logic [31:0]        rmy_s [0:N];
	logic [31:0]        shx_s [0:N];
	logic [31:0]        shy_s [0:N];

	logic               v_q;
	ilu_pkg::ctx_t      ctx_q;
	logic signed [31:0] x_q, y_q;
	logic [31:0]        magx, magy;

	// pick the final estimate from quotient magnitude and sign
	function automatic logic signed [31:0] pick(input logic kbad, input logic ovf,
			input logic neg, input logic [31:0] q, input logic signed [31:0] n);
		if (kbad) begin
			return n;
		end else if (ovf) begin
			return neg ? ilu_pkg::MIN32 : ilu_pkg::MAX32;
		end else if (neg) begin
			return (q > 32'h80000000) ? ilu_pkg::MIN32 : 32'(-q);
		end
		return q[31] ? ilu_pkg::MAX32 : q;
	endfunction

	assign magx = nx[31] ? 32'(-nx) : nx;
	assign magy = ny[31] ? 32'(-ny) : ny;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
			v_q    <= 1'b0;
		end else if (en) begin
			v_s[0] <= vin;
			v_q    <= v_s[N];
		end
	end

	// setup: magnitudes, overflow test, top remainder bits
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s[0]  <= ctx;
			k_s[0]    <= k;
			kbad_s[0] <= k[31] || (k == 32'd0);
			nx_s[0]   <= nx;
			ny_s[0]   <= ny;
			ngx_s[0]  <= nx[31];
			ngy_s[0]  <= ny[31];
			ovx_s[0]  <= {8'd0, magx} >= {k, 8'd0};
			ovy_s[0]  <= {8'd0, magy} >= {k, 8'd0};
			rmx_s[0]  <= {8'd0, magx[31:8]};
			rmy_s[0]  <= {8'd0, magy[31:8]};
			shx_s[0]  <= {magx[7:0], 24'd0};
			shy_s[0]  <= {magy[7:0], 24'd0};
		end
	end

	// one quotient bit per stage
	for (genvar i = 0; i < N; i++) begin : g_step
		logic [32:0] tx, ty;
		logic        gx, gy;

		assign tx = {rmx_s[i], shx_s[i][31]};
		assign ty = {rmy_s[i], shy_s[i][31]};
		assign gx = tx >= {1'b0, k_s[i]};
		assign gy = ty >= {1'b0, k_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[i+1]  <= ctx_s[i];
				k_s[i+1]    <= k_s[i];
				kbad_s[i+1] <= kbad_s[i];
				nx_s[i+1]   <= nx_s[i];
				ny_s[i+1]   <= ny_s[i];
				ngx_s[i+1]  <= ngx_s[i];
				ngy_s[i+1]  <= ngy_s[i];
				ovx_s[i+1]  <= ovx_s[i];
				ovy_s[i+1]  <= ovy_s[i];
				rmx_s[i+1]  <= gx ? 32'(tx - {1'b0, k_s[i]}) : tx[31:0];
				rmy_s[i+1]  <= gy ? 32'(ty - {1'b0, k_s[i]}) : ty[31:0];
				shx_s[i+1]  <= {shx_s[i][30:0], gx};
				shy_s[i+1]  <= {shy_s[i][30:0], gy};
			end
		end
	end

	// sign, saturation, bypass
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q.dx  <= ctx_s[N].dx;
			ctx_q.dy  <= ctx_s[N].dy;
			ctx_q.bad <= ctx_s[N].bad | kbad_s[N];
			x_q <= pick(kbad_s[N], ovx_s[N], ngx_s[N], shx_s[N], nx_s[N]);
			y_q <= pick(kbad_s[N], ovy_s[N], ngy_s[N], shy_s[N], ny_s[N]);
		end
	end

	assign vout    = v_q;
	assign ctx_out = ctx_q;
	assign x       = x_q;
	assign y       = y_q;

endmodule

`default_nettype wire

@@ hdl/ilu_iter.sv @@
// ----------------------------------------------------------------------------
// ilu_iter: one refinement pass
// Radial factor and numerators, then the division to the new estimate.
// ----------------------------------------------------------------------------
`default_nettype none

module ilu_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic signed [31:0] x,
	input  logic signed [31:0] y,
	input  ilu_pkg::ctx_t      ctx,
	input  ilu_pkg::coef_t     coef,
	output logic               vout,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output ilu_pkg::ctx_t      ctx_out
);

	logic               fv;
	ilu_pkg::ctx_t      fctx;
	logic signed [31:0] fnx, fny, fk;

	// polynomial, offsets, numerators
	ilu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (vin),
		.x      (x),
		.y      (y),
		.ctx    (ctx),
		.coef   (coef),
		.vout   (fv),
		.ctx_out(fctx),
		.nx     (fnx),
		.ny     (fny),
		.k      (fk)
	);

	// divide by the radial factor
	ilu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vin    (fv),
		.ctx    (fctx),
		.nx     (fnx),
		.ny     (fny),
		.k      (fk),
		.vout   (vout),
		.ctx_out(ctx_out),
		.x      (x_out),
		.y      (y_out)
	);

endmodule

`default_nettype wire

@@ hdl/iterative_lens_undistort_core.sv @@
// ----------------------------------------------------------------------------
// iterative_lens_undistort_core: fixed-point Brown-Conrady undistortion
// Twenty unrolled refinement passes, fully pipelined.
// ----------------------------------------------------------------------------
// One point enters per clock while no result is stalled at the output. Each
// of the 20 passes is 39 stages (5 for the polynomial and offsets, 1 divider
// setup, 32 one-bit divider steps, 1 for sign and saturation). The final
// divider register is the output register. While a result is held by
// out_stall the whole pipeline freezes and in_stall is raised; nothing is
// lost or repeated. The user must write coefficients on the cfg port only
// while no points are in flight; the block does not enforce this.
`default_nettype none

module iterative_lens_undistort_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] dist_x,
	input  logic signed [31:0] dist_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] undist_x,
	output logic signed [31:0] undist_y,
	output logic               bad_divisor
);

	localparam int IT = ilu_pkg::ITERATIONS;

	ilu_pkg::coef_t     coef_q;
	logic               en;
	logic               v_c  [0:IT];
	logic signed [31:0] x_c  [0:IT];
	logic signed [31:0] y_c  [0:IT];
	ilu_pkg::ctx_t      ctx_c[0:IT];

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ilu_pkg::REG_K1: coef_q.k1 <= cfg_data;
				ilu_pkg::REG_K2: coef_q.k2 <= cfg_data;
				ilu_pkg::REG_K3: coef_q.k3 <= cfg_data;
				ilu_pkg::REG_P1: coef_q.p1 <= cfg_data;
				ilu_pkg::REG_P2: coef_q.p2 <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold everything while the output transfer is stalled
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign v_c[0]       = in_valid && en;
	assign x_c[0]       = dist_x;
	assign y_c[0]       = dist_y;
	assign ctx_c[0].dx  = dist_x;
	assign ctx_c[0].dy  = dist_y;
	assign ctx_c[0].bad = 1'b0;

	// chain of passes
	for (genvar i = 0; i < IT; i++) begin : g_iter
		ilu_iter u_iter (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vin    (v_c[i]),
			.x      (x_c[i]),
			.y      (y_c[i]),
			.ctx    (ctx_c[i]),
			.coef   (coef_q),
			.vout   (v_c[i+1]),
			.x_out  (x_c[i+1]),
			.y_out  (y_c[i+1]),
			.ctx_out(ctx_c[i+1])
		);
	end

	assign out_valid   = v_c[IT];
	assign undist_x    = x_c[IT];
	assign undist_y    = y_c[IT];
	assign bad_divisor = ctx_c[IT].bad;

endmodule

`default_nettype wire

@@ hdl/ilu_checker.sv @@
// ----------------------------------------------------------------------------
// ilu_checker: port-level checks for the undistortion core
// Stall coupling, reset behavior and output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module ilu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] undist_x,
	input logic signed [31:0] undist_y,
	input logic               bad_divisor
);

	// input is held back only by a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// a stalled result freezes the intake
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input taken while result stalled");

	// no result right out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(undist_x)
			&& $stable(undist_y) && $stable(bad_divisor)))
		else $error("stalled result changed");

endmodule

bind iterative_lens_undistort_core ilu_checker u_ilu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.undist_x   (undist_x),
	.undist_y   (undist_y),
	.bad_divisor(bad_divisor)
);

`default_nettype wire
